/* rtl/hsm_pkg.sv */
package hsm_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int POOL_W   = 32;
    localparam int PAY_W    = 32;
    localparam int KEY_W    = 64;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_SORT   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]              action;
        logic [IDX_W-1:0]        handle_index;
        logic [POOL_W-1:0]       handle_pool;
        logic [PAY_W-1:0]        payload;
        logic signed [KEY_W-1:0] sort_key;
    } cmd_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [IDX_W-1:0]        new_index;
        logic [POOL_W-1:0]       new_pool;
        logic [PAY_W-1:0]        read_payload;
        logic signed [KEY_W-1:0] read_key;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0]        slot;
        logic [PAY_W-1:0]        payload;
        logic signed [KEY_W-1:0] key;
    } dense_t;

    localparam int DENSE_W = $bits(dense_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_POP,
        ST_INS_WRITE,
        ST_REM_MOVE,
        ST_RD_S2D,
        ST_RD_OUT,
        ST_SORT_GETI,
        ST_SORT_CMP,
        ST_SORT_PLACE,
        ST_MAP
    } state_t;

endpackage

/* rtl/hsm_ram.sv */
module hsm_ram
    import hsm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/hsm_key_cmp.sv */
module hsm_key_cmp
    import hsm_pkg::*;
(
    input  logic signed [KEY_W-1:0] a,
    input  logic signed [KEY_W-1:0] b,
    output logic                    gt
);

    assign gt = (a > b);

endmodule

/* rtl/handle_slot_map_with_sort.sv */
// Handle table with sortable packed store.
// Command channel: cmd is taken at a clock edge where start is high and busy
// is low. Exactly one result per command appears on result for one cycle
// with done high; the receiver cannot stall it.
// Pool id register: written by cfg_we / cfg_wdata. The user must write it only
// while the block is idle; the block itself does not enforce this.
// Insert pops a freed slot from the free list when one is held, else it takes
// the next unused slot; a sort with fewer than two live entries returns
// without sorting. The dense store has one read and one write port, so the
// insertion sort shifts one entry per cycle while scanning back, followed by
// a one-entry-per-cycle rebuild of the slot map.
// busy stays high from accept until done; the next command may start in the
// cycle done is shown.
// Reset clears the live bits, counters and pool id directly; no clearing
// pass is needed. Clear likewise resets the live bits and counters directly.
module handle_slot_map_with_sort
    import hsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [POOL_W-1:0] cfg_wdata
);

    state_t            state_reg, state_next;
    cmd_t              item_reg, item_next;
    logic [POOL_W-1:0] pool_reg;
    logic [CNT_W-1:0]  free_count_reg, free_count_next;
    logic [CNT_W-1:0]  live_count_reg, live_count_next;
    logic [CNT_W-1:0]  sparse_size_reg, sparse_size_next;
    logic [CAPACITY-1:0] live_reg, live_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    dense_t            cur_reg, cur_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic              s2d_we;
    logic [IDX_W-1:0]  s2d_waddr, s2d_wdata, s2d_raddr, s2d_rdata;
    logic              dn_we;
    logic [IDX_W-1:0]  dn_waddr, dn_raddr;
    dense_t            dn_wdata, dn_rdata;
    logic              fr_we;
    logic [IDX_W-1:0]  fr_waddr, fr_wdata, fr_raddr, fr_rdata;

    logic              key_gt;
    logic              handle_ok;
    logic [IDX_W-1:0]  last_idx;
    logic [CNT_W-1:0]  i_inc;

    hsm_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_s2d (
        .clk   (clk),
        .we    (s2d_we),
        .waddr (s2d_waddr),
        .wdata (s2d_wdata),
        .raddr (s2d_raddr),
        .rdata (s2d_rdata)
    );

    hsm_ram #(.WIDTH(DENSE_W), .DEPTH(CAPACITY)) u_dense (
        .clk   (clk),
        .we    (dn_we),
        .waddr (dn_waddr),
        .wdata (dn_wdata),
        .raddr (dn_raddr),
        .rdata (dn_rdata)
    );

    hsm_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    hsm_key_cmp u_cmp (
        .a  (cur_reg.key),
        .b  (dn_rdata.key),
        .gt (key_gt)
    );

    assign handle_ok = (item_reg.handle_pool == pool_reg) &&
                       ({1'b0, item_reg.handle_index} < sparse_size_reg) &&
                       live_reg[item_reg.handle_index];
    assign last_idx  = IDX_W'(live_count_reg - CNT_W'(1));
    assign i_inc     = i_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pool_reg        <= '0;
            free_count_reg  <= '0;
            live_count_reg  <= '0;
            sparse_size_reg <= '0;
            live_reg        <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            free_count_reg  <= free_count_next;
            live_count_reg  <= live_count_next;
            sparse_size_reg <= sparse_size_next;
            live_reg        <= live_next;
            done_reg        <= done_next;
            if (cfg_we)
            begin
                pool_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        slot_reg   <= slot_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        free_count_next  = free_count_reg;
        live_count_next  = live_count_reg;
        sparse_size_next = sparse_size_reg;
        live_next        = live_reg;
        slot_next        = slot_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        cur_next         = cur_reg;
        done_next        = 1'b0;
        result_next      = result_reg;

        s2d_we    = 1'b0;
        s2d_waddr = '0;
        s2d_wdata = '0;
        s2d_raddr = item_reg.handle_index;
        dn_we     = 1'b0;
        dn_waddr  = '0;
        dn_wdata  = cur_reg;
        dn_raddr  = '0;
        fr_we     = 1'b0;
        fr_waddr  = free_count_reg[IDX_W-1:0];
        fr_wdata  = item_reg.handle_index;
        fr_raddr  = IDX_W'(free_count_reg - CNT_W'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = cmd;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                result_next        = '0;
                result_next.status = STS_OK;
                state_next         = ST_IDLE;
                done_next          = 1'b1;
                case (item_reg.action)
                    ACT_INSERT:
                    begin
                        if (free_count_reg != '0)
                        begin
                            free_count_next = free_count_reg - CNT_W'(1);
                            done_next       = 1'b0;
                            state_next      = ST_INS_POP;
                        end
                        else if (!sparse_size_reg[IDX_W])
                        begin
                            slot_next        = sparse_size_reg[IDX_W-1:0];
                            sparse_size_next = sparse_size_reg + CNT_W'(1);
                            done_next        = 1'b0;
                            state_next       = ST_INS_WRITE;
                        end
                        else
                        begin
                            result_next.status = STS_FULL;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (handle_ok)
                        begin
                            dn_raddr   = last_idx;
                            done_next  = 1'b0;
                            state_next = ST_REM_MOVE;
                        end
                        else
                        begin
                            result_next.status = STS_INVALID;
                        end
                    end
                    ACT_READ:
                    begin
                        if (handle_ok)
                        begin
                            done_next  = 1'b0;
                            state_next = ST_RD_S2D;
                        end
                        else
                        begin
                            result_next.status = STS_INVALID;
                        end
                    end
                    ACT_SORT:
                    begin
                        if (live_count_reg > CNT_W'(1))
                        begin
                            i_next     = CNT_W'(1);
                            dn_raddr   = IDX_W'(1);
                            done_next  = 1'b0;
                            state_next = ST_SORT_GETI;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        live_next        = '0;
                        free_count_next  = '0;
                        live_count_next  = '0;
                        sparse_size_next = '0;
                    end
                    default:
                    begin
                        result_next.status = STS_OK;
                    end
                endcase
            end

            ST_INS_POP:
            begin
                slot_next  = fr_rdata;
                state_next = ST_INS_WRITE;
            end

            ST_INS_WRITE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (!live_count_reg[IDX_W])
                begin
                    dn_we            = 1'b1;
                    dn_waddr         = live_count_reg[IDX_W-1:0];
                    dn_wdata.slot    = slot_reg;
                    dn_wdata.payload = item_reg.payload;
                    dn_wdata.key     = item_reg.sort_key;
                    s2d_we           = 1'b1;
                    s2d_waddr        = slot_reg;
                    s2d_wdata        = live_count_reg[IDX_W-1:0];
                    live_next[slot_reg] = 1'b1;
                    live_count_next  = live_count_reg + CNT_W'(1);
                    result_next.new_index = slot_reg;
                    result_next.new_pool  = pool_reg;
                end
                else
                begin
                    result_next.status = STS_FULL;
                end
            end

            ST_REM_MOVE:
            begin
                if (s2d_rdata != last_idx)
                begin
                    dn_we     = 1'b1;
                    dn_waddr  = s2d_rdata;
                    dn_wdata  = dn_rdata;
                    s2d_we    = 1'b1;
                    s2d_waddr = dn_rdata.slot;
                    s2d_wdata = s2d_rdata;
                end
                live_count_next = live_count_reg - CNT_W'(1);
                live_next[item_reg.handle_index] = 1'b0;
                if (!free_count_reg[IDX_W])
                begin
                    fr_we           = 1'b1;
                    free_count_next = free_count_reg + CNT_W'(1);
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_RD_S2D:
            begin
                dn_raddr   = s2d_rdata;
                state_next = ST_RD_OUT;
            end

            ST_RD_OUT:
            begin
                result_next.read_payload = dn_rdata.payload;
                result_next.read_key     = dn_rdata.key;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SORT_GETI:
            begin
                cur_next   = dn_rdata;
                j_next     = i_reg[IDX_W-1:0];
                dn_raddr   = IDX_W'(i_reg - CNT_W'(1));
                state_next = ST_SORT_CMP;
            end

            ST_SORT_CMP:
            begin
                dn_we    = 1'b1;
                dn_waddr = j_reg;
                if (key_gt)
                begin
                    dn_wdata = dn_rdata;
                    j_next   = j_reg - IDX_W'(1);
                    if (j_reg != IDX_W'(1))
                    begin
                        dn_raddr = j_reg - IDX_W'(2);
                    end
                    else
                    begin
                        state_next = ST_SORT_PLACE;
                    end
                end
                else
                begin
                    i_next = i_inc;
                    if (i_inc < live_count_reg)
                    begin
                        dn_raddr   = i_inc[IDX_W-1:0];
                        state_next = ST_SORT_GETI;
                    end
                    else
                    begin
                        i_next     = '0;
                        dn_raddr   = '0;
                        state_next = ST_MAP;
                    end
                end
            end

            ST_SORT_PLACE:
            begin
                dn_we    = 1'b1;
                dn_waddr = j_reg;
                i_next   = i_inc;
                if (i_inc < live_count_reg)
                begin
                    dn_raddr   = i_inc[IDX_W-1:0];
                    state_next = ST_SORT_GETI;
                end
                else
                begin
                    // entry 0 is being written now; map it directly
                    s2d_we     = 1'b1;
                    s2d_waddr  = cur_reg.slot;
                    s2d_wdata  = '0;
                    i_next     = CNT_W'(1);
                    dn_raddr   = IDX_W'(1);
                    state_next = ST_MAP;
                end
            end

            ST_MAP:
            begin
                s2d_we    = 1'b1;
                s2d_waddr = dn_rdata.slot;
                s2d_wdata = i_reg[IDX_W-1:0];
                if (i_inc < live_count_reg)
                begin
                    i_next   = i_inc;
                    dn_raddr = i_inc[IDX_W-1:0];
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* tb/handle_slot_map_with_sort_test.sv */
`timescale 1ns / 1ps

module handle_slot_map_with_sort_test;
    import hsm_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cmd_t              cmd;
    logic              done;
    result_t           result;
    logic              cfg_we;
    logic [POOL_W-1:0] cfg_wdata;

    handle_slot_map_with_sort dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // predictor state
    logic [POOL_W-1:0]       pool_reg;
    logic [IDX_W-1:0]        slot_to_pos [CAPACITY];
    logic                    slot_live   [CAPACITY];
    logic [IDX_W-1:0]        pos_to_slot [CAPACITY];
    logic [PAY_W-1:0]        pos_payload [CAPACITY];
    logic signed [KEY_W-1:0] pos_key     [CAPACITY];
    logic [IDX_W-1:0]        freed       [CAPACITY];
    int                      freed_cnt;
    int                      live_cnt;
    int                      slots_used;

    cmd_t    pending_cmds[$];
    result_t expected_results[$];
    int      errors;
    int      driven;
    int      gap_left;
    int      burst_left;

    function automatic bit handle_valid(cmd_t c);
        return c.handle_pool == pool_reg && int'(c.handle_index) < slots_used
            && slot_live[c.handle_index];
    endfunction

    function automatic void store_clear();
        for (int i = 0; i < CAPACITY; i++)
            slot_live[i] = 1'b0;
        freed_cnt  = 0;
        live_cnt   = 0;
        slots_used = 0;
    endfunction

    function automatic result_t predict(cmd_t c);
        result_t r;
        int slot;
        int d;
        int last;
        int j;
        cmd_t tmp;
        logic [PAY_W-1:0] p;
        logic signed [KEY_W-1:0] k;
        logic [IDX_W-1:0] s;
        r = '0;
        case (c.action)
            ACT_INSERT:
            begin
                slot = -1;
                if (freed_cnt > 0)
                begin
                    freed_cnt--;
                    slot = int'(freed[freed_cnt]);
                end
                else if (slots_used < CAPACITY)
                begin
                    slot = slots_used;
                    slots_used++;
                end
                if (slot >= 0 && live_cnt < CAPACITY)
                begin
                    pos_payload[live_cnt] = c.payload;
                    pos_key[live_cnt]     = c.sort_key;
                    pos_to_slot[live_cnt] = IDX_W'(slot);
                    slot_to_pos[slot]     = IDX_W'(live_cnt);
                    slot_live[slot]       = 1'b1;
                    live_cnt++;
                    r.new_index = IDX_W'(slot);
                    r.new_pool  = pool_reg;
                end
                else
                    r.status = STS_FULL;
            end
            ACT_REMOVE:
            begin
                if (handle_valid(c))
                begin
                    d    = int'(slot_to_pos[c.handle_index]);
                    last = live_cnt - 1;
                    if (d != last)
                    begin
                        pos_payload[d] = pos_payload[last];
                        pos_key[d]     = pos_key[last];
                        pos_to_slot[d] = pos_to_slot[last];
                        slot_to_pos[pos_to_slot[last]] = IDX_W'(d);
                    end
                    live_cnt--;
                    slot_live[c.handle_index] = 1'b0;
                    if (freed_cnt < CAPACITY)
                    begin
                        freed[freed_cnt] = c.handle_index;
                        freed_cnt++;
                    end
                end
                else
                    r.status = STS_INVALID;
            end
            ACT_READ:
            begin
                if (handle_valid(c))
                begin
                    d = int'(slot_to_pos[c.handle_index]);
                    r.read_payload = pos_payload[d];
                    r.read_key     = pos_key[d];
                end
                else
                    r.status = STS_INVALID;
            end
            ACT_SORT:
            begin
                for (int i = 1; i < live_cnt; i++)
                begin
                    p = pos_payload[i];
                    k = pos_key[i];
                    s = pos_to_slot[i];
                    j = i;
                    while (j > 0 && k > pos_key[j-1])
                    begin
                        pos_payload[j] = pos_payload[j-1];
                        pos_key[j]     = pos_key[j-1];
                        pos_to_slot[j] = pos_to_slot[j-1];
                        j--;
                    end
                    pos_payload[j] = p;
                    pos_key[j]     = k;
                    pos_to_slot[j] = s;
                end
                for (int i = 0; i < live_cnt; i++)
                    slot_to_pos[pos_to_slot[i]] = IDX_W'(i);
            end
            ACT_CLEAR:
                store_clear();
            default:
                ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= '0;
            driven     <= 0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(), predict(cmd));
                driven <= driven + 1;
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd   <= pending_cmds.pop_front();
                    start <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                errors++;
            end
            else if (result !== expected_results[0])
            begin
                $display("%0t: mismatch expected %p actual %p", $time,
                         expected_results[0], result);
                errors++;
                void'(expected_results.pop_front());
            end
            else
                void'(expected_results.pop_front());
        end
    end

    function automatic cmd_t rand_cmd(int ins_w, int rem_w, int rd_w);
        cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        c.payload  = $urandom;
        c.sort_key = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: c.sort_key = $signed(64'($urandom_range(0, 7))) - 64'sd4;
            1: c.sort_key = {$urandom, $urandom} >>> $urandom_range(0, 63);
            default: ;
        endcase
        c.handle_pool  = ($urandom_range(0, 9) == 0) ? $urandom : pool_reg;
        c.handle_index = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                                     : IDX_W'($urandom_range(0, 40));
        if (r < ins_w)
            c.action = ACT_INSERT;
        else if (r < ins_w + rem_w)
            c.action = ACT_REMOVE;
        else if (r < ins_w + rem_w + rd_w)
            c.action = ACT_READ;
        else if (r < 97)
            c.action = ACT_SORT;
        else if (r < 98)
            c.action = ACT_CLEAR;
        else
            c.action = 3'($urandom_range(5, 7));
        return c;
    endfunction

    task automatic drain_and_write(logic [POOL_W-1:0] val);
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        pool_reg  = val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic push_cmd(logic [2:0] a, logic [IDX_W-1:0] i, logic [POOL_W-1:0] hp,
                            logic [PAY_W-1:0] p, logic signed [KEY_W-1:0] k);
        cmd_t c;
        c.action       = a;
        c.handle_index = i;
        c.handle_pool  = hp;
        c.payload      = p;
        c.sort_key     = k;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    initial
    begin
        logic [POOL_W-1:0] pools [4];
        cmd_t c;
        errors    = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        pool_reg  = '0;
        store_clear();
        pools[0] = 32'hFFFF_FFFF;
        pools[1] = 32'h0000_0000;
        pools[2] = 32'hA5C3_0F96;
        pools[3] = 32'h5A3C_F069;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        push_cmd(ACT_READ,   8'd0,   32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_INSERT, 8'd0,   32'd0, 32'hFFFF_FFFF, 64'sh7FFF_FFFF_FFFF_FFFF);
        push_cmd(ACT_INSERT, 8'd0,   32'd0, 32'd0, 64'sh8000_0000_0000_0000);
        push_cmd(ACT_INSERT, 8'd0,   32'd0, 32'h1234_5678, 64'sd5);
        push_cmd(ACT_INSERT, 8'd0,   32'd0, 32'h8765_4321, 64'sd5);
        push_cmd(ACT_INSERT, 8'd0,   32'd0, 32'h0BAD_F00D, -64'sd1);
        push_cmd(ACT_READ,   8'd0,   32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_READ,   8'd1,   32'd1, 32'd0, 64'sd0);
        push_cmd(ACT_READ,   8'd255, 32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_SORT,   8'd0,   32'd0, 32'd0, 64'sd0);
        for (int i = 0; i < 5; i++)
            push_cmd(ACT_READ, 8'(i), 32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_REMOVE, 8'd1,   32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_REMOVE, 8'd1,   32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_REMOVE, 8'd2,   32'hFFFF_FFFF, 32'd0, 64'sd0);
        push_cmd(ACT_INSERT, 8'd0,   32'd0, 32'h0000_0001, 64'sd0);
        push_cmd(ACT_READ,   8'd4,   32'd0, 32'd0, 64'sd0);
        push_cmd(3'd5,       8'd0,   32'd0, 32'd0, 64'sd0);
        push_cmd(3'd7,       8'hFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, -64'sd1);
        push_cmd(ACT_CLEAR,  8'd0,   32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_READ,   8'd0,   32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_INSERT, 8'd0,   32'd0, 32'd9, 64'sd9);

        // fill to capacity, then three more for the full case
        drain_and_write(pools[0]);
        for (int i = 0; i < CAPACITY + 2; i++)
            push_cmd(ACT_INSERT, 8'd0, 32'd0, $urandom, {$urandom, $urandom});
        push_cmd(ACT_READ,   8'd255, pools[0], 32'd0, 64'sd0);
        push_cmd(ACT_REMOVE, 8'd17,  pools[0], 32'd0, 64'sd0);
        push_cmd(ACT_INSERT, 8'd0,   32'd0, 32'd3, 64'sd3);
        push_cmd(ACT_SORT,   8'd0,   32'd0, 32'd0, 64'sd0);
        push_cmd(ACT_READ,   8'd17,  pools[0], 32'd0, 64'sd0);
        push_cmd(ACT_CLEAR,  8'd0,   32'd0, 32'd0, 64'sd0);

        // random phases with the pool id changing between them
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_and_write(pools[ph]);
            for (int n = 0; n < 40; n++)
            begin
                c = rand_cmd(ph == 3 ? 30 : 45, 20, 30);
                pending_cmds.insert(pending_cmds.size(), c);
            end
        end

        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
